// ===== hdl/rcrc_pkg.sv =====
// types, register codes, reset values and bit helpers for the reflected crc engine
package rcrc_pkg;

  typedef logic [31:0] crc_word_t;
  typedef logic [5:0]  crc_wid_t;
  typedef logic [7:0]  crc_byte_t;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLY     = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_INIT     = 3'd2,
    REG_REFL_IN  = 3'd3,
    REG_REFL_OUT = 3'd4,
    REG_FXOR     = 3'd5
  } reg_idx_t;

  // programmed settings, one field per register
  typedef struct packed {
    crc_word_t polynomial;
    crc_wid_t  crc_width;
    crc_word_t init_value;
    logic      reflect_in;
    logic      reflect_out;
    crc_word_t final_xor;
  } cfg_t;

  localparam crc_word_t RST_POLY     = 32'hF4AC_FB13;
  localparam crc_wid_t  RST_WIDTH    = 6'd32;
  localparam crc_word_t RST_INIT     = 32'hFFFF_FFFF;
  localparam logic      RST_REFL_IN  = 1'b1;
  localparam logic      RST_REFL_OUT = 1'b1;
  localparam crc_word_t RST_FXOR     = 32'hFFFF_FFFF;

  localparam crc_word_t ALL_ONES  = 32'hFFFF_FFFF;
  localparam crc_wid_t  MIN_WIDTH = 6'd8;
  localparam crc_wid_t  WORD_BITS = 6'd32;

  // width in use: at least eight, at most the build limit
  function automatic crc_wid_t clamp_width(crc_wid_t w, crc_wid_t top);
    crc_wid_t r;
    if (w < MIN_WIDTH) begin
      r = MIN_WIDTH;
    end else if (w > top) begin
      r = top;
    end else begin
      r = w;
    end
    return r;
  endfunction

  // low w bits set, w in 8..32
  function automatic crc_word_t width_mask(crc_wid_t w);
    return ALL_ONES >> (WORD_BITS - w);
  endfunction

  function automatic crc_word_t reverse32(crc_word_t v);
    crc_word_t r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // bit reversal over the low w bits, upper bits cleared
  function automatic crc_word_t reverse_width(crc_word_t v, crc_wid_t w);
    return reverse32(v) >> (WORD_BITS - w);
  endfunction

  function automatic crc_byte_t reverse8(crc_byte_t v);
    crc_byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/rcrc_cfg_regs.sv =====
// configuration register file with reload request on width or init writes
module rcrc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rcrc_pkg::cfg_idx_t cfg_index,
  input  rcrc_pkg::crc_word_t cfg_data,
  output rcrc_pkg::cfg_t     cfg,
  output rcrc_pkg::cfg_t     cfg_nxt,
  output logic               reload
);

  rcrc_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    reload  = 1'b0;
    if (wr_en) begin
      case (rcrc_pkg::reg_idx_t'(cfg_index))
        rcrc_pkg::REG_POLY: begin
          cfg_nxt.polynomial = cfg_data;
        end
        rcrc_pkg::REG_WIDTH: begin
          cfg_nxt.crc_width = cfg_data[5:0];
          reload = 1'b1;
        end
        rcrc_pkg::REG_INIT: begin
          cfg_nxt.init_value = cfg_data;
          reload = 1'b1;
        end
        rcrc_pkg::REG_REFL_IN: begin
          cfg_nxt.reflect_in = cfg_data[0];
        end
        rcrc_pkg::REG_REFL_OUT: begin
          cfg_nxt.reflect_out = cfg_data[0];
        end
        rcrc_pkg::REG_FXOR: begin
          cfg_nxt.final_xor = cfg_data;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial  <= rcrc_pkg::RST_POLY;
      cfg_r.crc_width   <= rcrc_pkg::RST_WIDTH;
      cfg_r.init_value  <= rcrc_pkg::RST_INIT;
      cfg_r.reflect_in  <= rcrc_pkg::RST_REFL_IN;
      cfg_r.reflect_out <= rcrc_pkg::RST_REFL_OUT;
      cfg_r.final_xor   <= rcrc_pkg::RST_FXOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/rcrc_byte_engine.sv =====
// running crc register and the unrolled eight-step byte update
module rcrc_byte_engine #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcrc_pkg::cfg_t      cfg,
  input  rcrc_pkg::cfg_t      cfg_nxt,
  input  logic                reload,
  input  logic                fire,
  input  rcrc_pkg::crc_byte_t data_byte,
  input  logic                last_byte,
  output rcrc_pkg::crc_word_t crc_result
);

  localparam int TOP_RAW = (MAX_CRC_WIDTH < 32) ? MAX_CRC_WIDTH : 32;
  localparam int TOP_W   = (TOP_RAW < 8) ? 8 : TOP_RAW;
  localparam rcrc_pkg::crc_wid_t TOP_WIDTH = rcrc_pkg::crc_wid_t'(TOP_W);

  rcrc_pkg::crc_word_t running_crc_r;
  rcrc_pkg::crc_word_t running_crc_nxt;
  rcrc_pkg::crc_wid_t  act_w;
  rcrc_pkg::crc_word_t mask;
  rcrc_pkg::crc_word_t rpoly;
  rcrc_pkg::crc_byte_t feed;
  rcrc_pkg::crc_word_t crc_upd;
  rcrc_pkg::crc_word_t out_raw;
  rcrc_pkg::crc_word_t reload_val;
  rcrc_pkg::crc_word_t rst_val;

  // width, mask and reflected polynomial from the settings
  assign act_w = rcrc_pkg::clamp_width(cfg.crc_width, TOP_WIDTH);
  assign mask  = rcrc_pkg::width_mask(act_w);
  assign rpoly = rcrc_pkg::reverse_width(cfg.polynomial & mask, act_w);
  assign feed  = cfg.reflect_in ? data_byte : rcrc_pkg::reverse8(data_byte);

  // byte update: eight shift and conditional xor steps
  always_comb begin
    rcrc_pkg::crc_word_t c;
    c = (running_crc_r & mask) ^ {24'd0, feed};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end
    crc_upd = c & mask;
  end

  // finished value for the last byte
  assign out_raw    = cfg.reflect_out ? crc_upd : rcrc_pkg::reverse_width(crc_upd, act_w);
  assign crc_result = (out_raw ^ cfg.final_xor) & mask;

  // start value after a width or init write, taken from the new settings
  assign reload_val = cfg_nxt.init_value
                    & rcrc_pkg::width_mask(rcrc_pkg::clamp_width(cfg_nxt.crc_width, TOP_WIDTH));
  assign rst_val    = rcrc_pkg::RST_INIT
                    & rcrc_pkg::width_mask(rcrc_pkg::clamp_width(rcrc_pkg::RST_WIDTH, TOP_WIDTH));

  // next running value
  always_comb begin
    running_crc_nxt = running_crc_r;
    if (reload) begin
      running_crc_nxt = reload_val;
    end else if (fire) begin
      running_crc_nxt = last_byte ? (cfg.init_value & mask) : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= rst_val;
    end else begin
      running_crc_r <= running_crc_nxt;
    end
  end

endmodule

// ===== hdl/configurable_reflected_crc.sv =====
// top level: input item register, crc byte engine and result register
//
// Byte-serial reflected CRC of 8 to 32 bits with programmable polynomial, init, final xor and
// in/out reflection. One byte is accepted every clock cycle unless in_stall holds it; a message's
// crc goes from the input item register through the byte engine into the result register behind
// the result port. The cycle time is set by the eight-step shift/xor byte update between the input
// item register and the running crc and result registers. The result channel can stall while new
// bytes keep arriving: only a last byte waits for the result register to free up. Configuration is
// taken at any time, cfg_ready always high; a width or init write restarts the running crc.
module configurable_reflected_crc #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rcrc_pkg::cfg_t      cfg;
  rcrc_pkg::cfg_t      cfg_nxt;
  logic                reload;
  logic                in_vld_r;
  logic                in_vld_nxt;
  rcrc_pkg::crc_byte_t in_byte_r;
  logic                in_last_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  rcrc_pkg::crc_word_t out_crc_r;
  rcrc_pkg::crc_word_t crc_result;
  logic                fire;

  rcrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_nxt   (cfg_nxt),
    .reload    (reload)
  );

  rcrc_byte_engine #(
    .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_nxt    (cfg_nxt),
    .reload     (reload),
    .fire       (fire),
    .data_byte  (in_byte_r),
    .last_byte  (in_last_r),
    .crc_result (crc_result)
  );

  // an item moves on unless it is a last byte and the result register is full and stalled
  assign fire     = in_vld_r && (!in_last_r || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  // input item register
  assign in_vld_nxt = in_stall ? in_vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (fire && in_last_r) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      out_crc_r <= crc_result;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_crc_result = out_crc_r;

endmodule

// ===== tb/sv/configurable_reflected_crc_checker.sv =====
// crc engine checker: follows config and input channels, predicts and compares each crc
module configurable_reflected_crc_checker #(
  parameter int MAX_CRC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_crc_result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  rcrc_pkg::cfg_t      crc_cfg;
  rcrc_pkg::crc_word_t crc_reg;
  rcrc_pkg::crc_word_t crc_queue[$];
  int                  n_fail = 0;

  assign fail_count = n_fail;

  // width actually used: at least eight, at most the build limit and 32
  function automatic int unsigned used_width(rcrc_pkg::crc_wid_t cw);
    int unsigned top_w;
    int unsigned w;
    top_w = (MAX_CRC_WIDTH < 32) ? MAX_CRC_WIDTH : 32;
    if (top_w < 8) top_w = 8;
    w = 32'(cw);
    if (w < 8) w = 8;
    if (w > top_w) w = top_w;
    return w;
  endfunction

  function automatic rcrc_pkg::crc_word_t low_mask(int unsigned w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return m[31:0];
  endfunction

  // mirror the low w bits, clear the rest
  function automatic rcrc_pkg::crc_word_t flip_low(rcrc_pkg::crc_word_t v, int unsigned w);
    rcrc_pkg::crc_word_t r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < w) r[w-1-i] = v[i];
    end
    return r;
  endfunction

  function automatic rcrc_pkg::crc_word_t start_crc(rcrc_pkg::cfg_t c);
    return c.init_value & low_mask(used_width(c.crc_width));
  endfunction

  // one byte through the right-shifting register, eight shift/xor steps
  function automatic rcrc_pkg::crc_word_t next_crc(rcrc_pkg::crc_word_t cur,
                                                   rcrc_pkg::crc_byte_t b,
                                                   rcrc_pkg::cfg_t c);
    int unsigned         w;
    rcrc_pkg::crc_word_t mask;
    rcrc_pkg::crc_word_t rpoly;
    rcrc_pkg::crc_word_t fb;
    rcrc_pkg::crc_word_t acc;
    w     = used_width(c.crc_width);
    mask  = low_mask(w);
    rpoly = flip_low(c.polynomial & mask, w);
    fb    = {24'd0, b};
    if (!c.reflect_in) fb = flip_low(fb, 8);
    acc = (cur & mask) ^ fb;
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
    end
    return acc & mask;
  endfunction

  // output reflection and final xor on a finished message
  function automatic rcrc_pkg::crc_word_t finish_crc(rcrc_pkg::crc_word_t cur,
                                                     rcrc_pkg::cfg_t c);
    int unsigned         w;
    rcrc_pkg::crc_word_t r;
    w = used_width(c.crc_width);
    r = cur;
    if (!c.reflect_out) r = flip_low(r, w);
    return (r ^ c.final_xor) & low_mask(w);
  endfunction

  always @(posedge clk) begin
    rcrc_pkg::crc_word_t want;
    if (!rst_n) begin
      crc_cfg.polynomial  = rcrc_pkg::RST_POLY;
      crc_cfg.crc_width   = rcrc_pkg::RST_WIDTH;
      crc_cfg.init_value  = rcrc_pkg::RST_INIT;
      crc_cfg.reflect_in  = rcrc_pkg::RST_REFL_IN;
      crc_cfg.reflect_out = rcrc_pkg::RST_REFL_OUT;
      crc_cfg.final_xor   = rcrc_pkg::RST_FXOR;
      crc_reg = start_crc(crc_cfg);
      crc_queue.delete();
    end else begin
      // register writes; width and init restart the running crc
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcrc_pkg::REG_POLY: crc_cfg.polynomial = cfg_data;
          rcrc_pkg::REG_WIDTH: begin
            crc_cfg.crc_width = cfg_data[5:0];
            crc_reg = start_crc(crc_cfg);
          end
          rcrc_pkg::REG_INIT: begin
            crc_cfg.init_value = cfg_data;
            crc_reg = start_crc(crc_cfg);
          end
          rcrc_pkg::REG_REFL_IN:  crc_cfg.reflect_in  = cfg_data[0];
          rcrc_pkg::REG_REFL_OUT: crc_cfg.reflect_out = cfg_data[0];
          rcrc_pkg::REG_FXOR:     crc_cfg.final_xor   = cfg_data;
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && !in_stall) begin
        crc_reg = next_crc(crc_reg, in_data_byte, crc_cfg);
        if (in_last_byte) begin
          crc_queue.push_back(finish_crc(crc_reg, crc_cfg));
          crc_reg = start_crc(crc_cfg);
        end
      end
      // accepted result item against the oldest prediction
      if (out_valid && !out_stall) begin
        if (crc_queue.size() == 0) begin
          $error("crc_result: expected nothing, actual %h", out_crc_result);
          n_fail++;
        end else begin
          want = crc_queue.pop_front();
          if (out_crc_result !== want) begin
            $error("crc_result: expected %h, actual %h", want, out_crc_result);
            n_fail++;
          end
        end
      end
    end
    pending_results <= crc_queue.size();
  end

endmodule

// ===== tb/sv/configurable_reflected_crc_tb.sv =====
// testbench top for the reflected crc engine: clock, reset, stimulus and verdict
module configurable_reflected_crc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int                 MAX_WIDTH    = 32;
  localparam int                 ITEM_TARGET  = 700;
  localparam int                 DRAIN_CYCLES = 8;
  localparam int                 DRAIN_LIMIT  = 100000;
  localparam rcrc_pkg::cfg_idx_t SPARE_IDX_LO = 3'd6;
  localparam rcrc_pkg::cfg_idx_t SPARE_IDX_HI = 3'd7;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte   = 8'd0;
  logic        in_last_byte   = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [31:0] out_crc_result;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index      = 3'd0;
  logic [31:0] cfg_data       = 32'd0;

  int crc_fail_count;
  int crc_pending;
  int gap_pct   = 0;
  int stall_pct = 0;
  int n_bytes   = 0;
  int n_msgs    = 0;
  int n_cfg     = 0;

  always #5 clk = ~clk;

  configurable_reflected_crc #(
    .MAX_CRC_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_crc_result (out_crc_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  configurable_reflected_crc_checker #(
    .MAX_CRC_WIDTH (MAX_WIDTH)
  ) i_crc_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_crc_result  (out_crc_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (crc_fail_count),
    .pending_results (crc_pending)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 58;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 58;
      end
      default: begin
        gap_pct   = 9;
        stall_pct = 9;
      end
    endcase
  endtask

  task automatic write_reg(rcrc_pkg::cfg_idx_t idx, rcrc_pkg::crc_word_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_cfg++;
  endtask

  // one byte item, after a random number of idle cycles
  task automatic send_byte(rcrc_pkg::crc_byte_t b, logic last);
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid     = 1'b0;
      in_data_byte = 8'($urandom_range(255));
      in_last_byte = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (in_stall);
    n_bytes++;
    if (last) n_msgs++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // let all results drain and the byte pipeline settle before a register write
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (crc_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic rcrc_pkg::crc_word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return rcrc_pkg::ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // mostly short messages, now and then a long one
  function automatic int pick_length();
    if ($urandom_range(19) == 0) return $urandom_range(9, 32);
    return $urandom_range(1, 8);
  endfunction

  // random subset of registers, extremes and out-of-range widths included
  task automatic randomise_config();
    rcrc_pkg::crc_word_t v;
    int unsigned         w;
    if ($urandom_range(1)) write_reg(rcrc_pkg::REG_POLY, pick_word());
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0:       w = 8;
        1:       w = 32;
        2:       w = $urandom_range(63);
        default: w = $urandom_range(8, 32);
      endcase
      v = $urandom;
      v[5:0] = w[5:0];
      write_reg(rcrc_pkg::REG_WIDTH, v);
    end
    if ($urandom_range(1)) write_reg(rcrc_pkg::REG_INIT, pick_word());
    if ($urandom_range(1)) write_reg(rcrc_pkg::REG_REFL_IN, $urandom);
    if ($urandom_range(1)) write_reg(rcrc_pkg::REG_REFL_OUT, $urandom);
    if ($urandom_range(1)) write_reg(rcrc_pkg::REG_FXOR, pick_word());
    if ($urandom_range(9) == 0) begin
      write_reg($urandom_range(1) ? SPARE_IDX_LO : SPARE_IDX_HI, $urandom);
    end
  endtask

  initial begin
    int start_bytes;
    int phase;
    int drain;
    int total;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_idling(IDLE_NONE);

    // reset settings: single-byte messages at both byte extremes, then a short one
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_quiet();

    // narrowest width, no reflection on either side, zero init and xor
    write_reg(rcrc_pkg::REG_WIDTH, 32'd8);
    write_reg(rcrc_pkg::REG_POLY, 32'h0000_0007);
    write_reg(rcrc_pkg::REG_INIT, '0);
    write_reg(rcrc_pkg::REG_REFL_IN, 32'd0);
    write_reg(rcrc_pkg::REG_REFL_OUT, 32'd0);
    write_reg(rcrc_pkg::REG_FXOR, '0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_quiet();

    // full width, all-ones polynomial
    write_reg(rcrc_pkg::REG_WIDTH, 32'd32);
    write_reg(rcrc_pkg::REG_POLY, rcrc_pkg::ALL_ONES);
    write_reg(rcrc_pkg::REG_REFL_IN, 32'd1);
    write_reg(rcrc_pkg::REG_REFL_OUT, 32'd1);
    write_reg(rcrc_pkg::REG_FXOR, rcrc_pkg::ALL_ONES);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_quiet();

    // widths below eight and above 32 clamp
    write_reg(rcrc_pkg::REG_POLY, 32'h0000_009B);
    write_reg(rcrc_pkg::REG_WIDTH, 32'd0);
    send_byte(8'hA5, 1'b1);
    wait_quiet();
    write_reg(rcrc_pkg::REG_WIDTH, 32'd63);
    send_byte(8'h3C, 1'b1);
    wait_quiet();
    write_reg(rcrc_pkg::REG_WIDTH, 32'd33);
    send_byte(8'hC3, 1'b1);
    wait_quiet();

    // 16-bit, then register writes in the middle of a message
    write_reg(rcrc_pkg::REG_WIDTH, 32'd16);
    write_reg(rcrc_pkg::REG_POLY, 32'h0000_1021);
    write_reg(rcrc_pkg::REG_INIT, 32'h0000_FFFF);
    write_reg(rcrc_pkg::REG_REFL_IN, 32'd0);
    write_reg(rcrc_pkg::REG_FXOR, '0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56, 1'b0);
    wait_quiet();
    // init write drops the partial message
    write_reg(rcrc_pkg::REG_INIT, 32'h0000_1D0F);
    send_byte(8'h78, 1'b1);
    send_byte(8'hE7, 1'b0);
    wait_quiet();
    // width write drops it too
    write_reg(rcrc_pkg::REG_WIDTH, 32'd24);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h9A, 1'b0);
    wait_quiet();
    // other writes apply from the next byte, message carries on
    write_reg(rcrc_pkg::REG_REFL_OUT, 32'd0);
    send_byte(8'hBC, 1'b1);
    wait_quiet();
    // writes beyond the register list change nothing
    write_reg(SPARE_IDX_LO, rcrc_pkg::ALL_ONES);
    write_reg(SPARE_IDX_HI, 32'h1234_5678);
    send_byte(8'h11, 1'b1);
    wait_quiet();

    // random phases, each with new settings and its own idling pattern
    start_bytes = n_bytes;
    phase = 0;
    while (n_bytes - start_bytes < ITEM_TARGET) begin
      set_idling(idle_mode_t'(phase % 4));
      randomise_config();
      repeat ($urandom_range(2, 8)) send_message(pick_length());
      // now and then leave a message unfinished across the next writes
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)), 1'b0);
      end
      wait_quiet();
      phase++;
    end

    // final drain
    @(negedge clk);
    in_valid = 1'b0;
    drain = 0;
    while (crc_pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    total = crc_fail_count + crc_pending;

    $display("summary: %0d bytes, %0d messages, %0d register writes, %0d random phases",
             n_bytes, n_msgs, n_cfg, phase);
    $display("summary: widths 8 to 32 plus clamped ones, both reflections, four idling patterns");
    if (total == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
